FILE: rtl/lpd_pkg.sv
// Package for the length-prefixed deframer: widths, codes, word types.
package lpd_pkg;

  // Width of the cap register and of the byte counters bounded by it
  localparam int CAP_WIDTH  = 27;
  localparam int PART_W     = 25;
  localparam int IDX_W      = 24;
  localparam int LEN_W      = 32;
  localparam int HDR_BYTES  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = (CAP_WIDTH > PART_W) ? CAP_WIDTH : PART_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;

  // Register reset values
  localparam logic [PART_W-1:0]    PART_COUNT_RESET = PART_W'(1);
  localparam logic [CAP_WIDTH-1:0] CAP_RESET =
    (CAP_WIDTH > 26) ? CAP_WIDTH'(64'd1 << 26) : '0;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAP_BYTES  = 2'd1;

  // Result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NO_LENGTH = 3'd1;
  localparam logic [2:0] ERR_PART_CAP  = 3'd2;
  localparam logic [2:0] ERR_BLOB_CAP  = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED = 3'd4;
  localparam logic [2:0] ERR_EXTRA     = 3'd5;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_SWALLOW
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       byte_valid;
    logic       blob_end;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       payload_byte;
    logic [IDX_W-1:0] part_index;
    logic             part_end;
    logic [2:0]       error_code;
  } out_word_t;

endpackage

FILE: rtl/length_prefixed_deframer.sv
// Length-prefixed deframer: header parse, cap checks, result queue.
// A word accepted at one edge shows its first result on out_valid right after that edge,
//   behind any results already queued.
// Throughput: one input word per cycle while in_ready is high; a word that ends a part
//   and closes the blob gives two results, drained one per cycle while out_ready is high.
// in_ready drops while the four-entry result queue holds three or more (room kept for two).
// Reset (rst_n low, synchronous): blob state cleared, part_count = 1, cap_bytes = 2^26.
module length_prefixed_deframer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lpd_pkg::in_word_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lpd_pkg::out_word_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lpd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW = lpd_pkg::CAP_WIDTH;
  localparam int PW = lpd_pkg::PART_W;

  // Configuration registers
  logic [PW-1:0] part_count_r;
  logic [CW-1:0] cap_r;

  // Blob state
  lpd_pkg::phase_t phase_r, phase_stp, phase_nxt;
  logic [1:0]      hbc_r, hbc_stp, hbc_nxt;
  logic [23:0]     shift_r, shift_stp, shift_nxt;
  logic [CW-1:0]   left_r, left_stp, left_nxt;
  logic [PW-1:0]   part_r, part_stp, part_nxt;
  logic [CW-1:0]   bcnt_r, bcnt_stp, bcnt_nxt;
  logic [2:0]      lerr_r, lerr_stp, lerr_nxt;

  // Result queue
  lpd_pkg::out_word_t           q_r [lpd_pkg::QUEUE_DEPTH];
  logic [lpd_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [lpd_pkg::QCNT_W-1:0]   cnt_r;

  logic                         in_acc, pop, byte_go, blob_close;
  logic                         extra_flt, blob_full, hdr_last, last_byte;
  logic                         len_over, fit_over, len_zero, byte_res;
  logic [CW-1:0]                bcnt_inc;
  logic [lpd_pkg::LEN_W-1:0]    len;
  logic [CW:0]                  fit_sum;
  logic [2:0]                   end_err;
  lpd_pkg::out_word_t           res_byte, res_end, push0, push1;
  logic [1:0]                   n_push;

  assign cfg_ready  = 1'b1;
  assign in_ready   = (cnt_r <= lpd_pkg::QCNT_W'(lpd_pkg::QUEUE_DEPTH - 2));
  assign in_acc     = in_valid & in_ready;
  assign out_valid  = (cnt_r != '0);
  assign out_data   = q_r[rd_ptr_r];
  assign pop        = out_valid & out_ready;
  assign byte_go    = in_acc & in_data.byte_valid & (phase_r != lpd_pkg::PH_SWALLOW);
  assign blob_close = in_acc & in_data.blob_end;

  // Decode checks on the current byte
  assign extra_flt = (phase_r == lpd_pkg::PH_HEADER) && (hbc_r == 2'd0) &&
                     (part_r >= part_count_r);
  assign blob_full = (bcnt_r >= cap_r);
  assign bcnt_inc  = bcnt_r + CW'(1);
  assign hdr_last  = (hbc_r == 2'(lpd_pkg::HDR_BYTES - 1));
  assign len       = {shift_r, in_data.byte_value};
  assign len_over  = (len > lpd_pkg::LEN_W'(cap_r));
  assign fit_sum   = {1'b0, bcnt_inc} + {1'b0, len[CW-1:0]};
  assign fit_over  = (fit_sum > {1'b0, cap_r});
  assign len_zero  = (len == '0);
  assign last_byte = (left_r <= CW'(1));

  // Advance blob state for the byte
  always_comb begin
    phase_stp = phase_r;
    hbc_stp   = hbc_r;
    shift_stp = shift_r;
    left_stp  = left_r;
    part_stp  = part_r;
    bcnt_stp  = bcnt_r;
    lerr_stp  = lerr_r;
    if (byte_go) begin
      if (extra_flt) begin
        lerr_stp  = lpd_pkg::ERR_EXTRA;
        phase_stp = lpd_pkg::PH_SWALLOW;
      end else if (blob_full) begin
        lerr_stp  = lpd_pkg::ERR_BLOB_CAP;
        phase_stp = lpd_pkg::PH_SWALLOW;
      end else begin
        bcnt_stp = bcnt_inc;
        if (phase_r == lpd_pkg::PH_HEADER) begin
          shift_stp = {shift_r[15:0], in_data.byte_value};
          hbc_stp   = hbc_r + 2'd1;
          if (hdr_last) begin
            hbc_stp   = '0;
            shift_stp = '0;
            if (len_over) begin
              lerr_stp  = lpd_pkg::ERR_PART_CAP;
              phase_stp = lpd_pkg::PH_SWALLOW;
            end else if (fit_over) begin
              lerr_stp  = lpd_pkg::ERR_BLOB_CAP;
              phase_stp = lpd_pkg::PH_SWALLOW;
            end else if (len_zero) begin
              part_stp = part_r + PW'(1);
            end else begin
              left_stp  = len[CW-1:0];
              phase_stp = lpd_pkg::PH_PAYLOAD;
            end
          end
        end else begin
          left_stp = last_byte ? '0 : left_r - CW'(1);
          if (last_byte) begin
            part_stp  = part_r + PW'(1);
            phase_stp = lpd_pkg::PH_HEADER;
          end
        end
      end
    end
  end

  // Drop blob state when the blob closes
  always_comb begin
    phase_nxt = phase_stp;
    hbc_nxt   = hbc_stp;
    shift_nxt = shift_stp;
    left_nxt  = left_stp;
    part_nxt  = part_stp;
    bcnt_nxt  = bcnt_stp;
    lerr_nxt  = lerr_stp;
    if (blob_close) begin
      phase_nxt = lpd_pkg::PH_HEADER;
      hbc_nxt   = '0;
      shift_nxt = '0;
      left_nxt  = '0;
      part_nxt  = '0;
      bcnt_nxt  = '0;
      lerr_nxt  = lpd_pkg::ERR_NONE;
    end
  end

  // Build the results of this word
  always_comb begin
    byte_res = byte_go && !extra_flt && !blob_full &&
               ((phase_r == lpd_pkg::PH_PAYLOAD) ||
                (hdr_last && !len_over && !fit_over && len_zero));
    res_byte              = '0;
    res_byte.part_index   = part_r[lpd_pkg::IDX_W-1:0];
    res_byte.part_end     = 1'b1;
    res_byte.kind         = lpd_pkg::KIND_EMPTY;
    if (phase_r == lpd_pkg::PH_PAYLOAD) begin
      res_byte.kind         = lpd_pkg::KIND_BYTE;
      res_byte.payload_byte = in_data.byte_value;
      res_byte.part_end     = last_byte;
    end

    end_err = lerr_stp;
    if (lerr_stp == lpd_pkg::ERR_NONE) begin
      if (phase_stp == lpd_pkg::PH_PAYLOAD) begin
        end_err = lpd_pkg::ERR_TRUNCATED;
      end else if ((hbc_stp != '0) || (part_stp < part_count_r)) begin
        end_err = lpd_pkg::ERR_NO_LENGTH;
      end
    end
    res_end            = '0;
    res_end.error_code = end_err;
    res_end.kind       = (end_err != lpd_pkg::ERR_NONE) ? lpd_pkg::KIND_ERROR
                                                        : lpd_pkg::KIND_DONE;

    push0 = byte_res ? res_byte : res_end;
    push1 = res_end;
    n_push = {1'b0, byte_res} + {1'b0, blob_close};
  end

  // Hold configuration; write on the config handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_count_r <= lpd_pkg::PART_COUNT_RESET;
      cap_r        <= lpd_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lpd_pkg::REG_PART_COUNT: part_count_r <= cfg_data[PW-1:0];
        lpd_pkg::REG_CAP_BYTES:  cap_r        <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // Update blob state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lpd_pkg::PH_HEADER;
      hbc_r   <= '0;
      shift_r <= '0;
      left_r  <= '0;
      part_r  <= '0;
      bcnt_r  <= '0;
      lerr_r  <= lpd_pkg::ERR_NONE;
    end else begin
      phase_r <= phase_nxt;
      hbc_r   <= hbc_nxt;
      shift_r <= shift_nxt;
      left_r  <= left_nxt;
      part_r  <= part_nxt;
      bcnt_r  <= bcnt_nxt;
      lerr_r  <= lerr_nxt;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + lpd_pkg::QPTR_W'(n_push);
      rd_ptr_r <= rd_ptr_r + lpd_pkg::QPTR_W'(pop);
      cnt_r    <= cnt_r + lpd_pkg::QCNT_W'(n_push) - lpd_pkg::QCNT_W'(pop);
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_r[wr_ptr_r] <= push0;
    end
    if (n_push == 2'd2) begin
      q_r[wr_ptr_r + lpd_pkg::QPTR_W'(1)] <= push1;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= lpd_pkg::QCNT_W'(lpd_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == cnt_r[lpd_pkg::QPTR_W-1:0])
    else $error("queue pointers disagree with fill count");

  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    blob_close |=> (phase_r == lpd_pkg::PH_HEADER) && (bcnt_r == '0) &&
                   (part_r == '0) && (lerr_r == lpd_pkg::ERR_NONE))
    else $error("blob state not cleared after blob end");

  a_err_swallow: assert property (@(posedge clk) disable iff (!rst_n)
    (lerr_r != lpd_pkg::ERR_NONE) |-> (phase_r == lpd_pkg::PH_SWALLOW))
    else $error("latched error outside swallow phase");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(cfg_valid) && $stable(cap_r) |-> bcnt_r <= cap_r ||
    $past(bcnt_r) == bcnt_r)
    else $error("blob byte count passed the cap");
`endif

endmodule
